// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
// Depends on nothing; included by the checker module pvp_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The antecedent implies the consequent at the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/pvp_pkg.sv
// Types and constants of the point view projection block.
// Depends on nothing; used by all RTL modules and the checker.
package pvp_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_COS_PHI   = 3'd0;
    localparam logic [2:0] REG_SIN_PHI   = 3'd1;
    localparam logic [2:0] REG_COS_THETA = 3'd2;
    localparam logic [2:0] REG_SIN_THETA = 3'd3;
    localparam logic [2:0] REG_EYE_Z     = 3'd4;
    localparam logic [2:0] REG_VIEW_Z    = 3'd5;
    localparam logic [2:0] REG_HALF_W    = 3'd6;
    localparam logic [2:0] REG_HALF_H    = 3'd7;

    localparam int TRIG_FRAC = 14;

    // Quotient bits resolved by the divider; larger quotients saturate anyway.
    localparam int DIV_QW  = 34;
    localparam int DIV_LAT = DIV_QW + 2;
    localparam int FRONT_LAT = 6;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + 1;

    // Side information that travels alongside the divider.
    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic        dz;
        logic        flt;
        logic [31:0] tint;
    } side_t;

endpackage

// File: rtl/point_view_projection_top.sv
// Point view projection block: rotation, perspective divide and screen offset.
// Depends on pvp_pkg and pvp_div.
//
// One request is taken every clock cycle; busy is always low. Each result
// appears on done after its request has passed the six-stage rotation and
// scaling front end, the divider's 36 stages (entry, one per quotient bit,
// rounding) and the output register. The receiver cannot stall, so results
// leave in request order. The user must write registers only while no
// request is in flight; the block itself does not enforce it.
module point_view_projection_top
    import pvp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] tint,
    output logic        done,
    output logic [31:0] screen_x,
    output logic [31:0] screen_y,
    output logic [31:0] plane_z,
    output logic [31:0] tint_out,
    output logic        fault,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic signed [15:0] cos_phi_reg, sin_phi_reg, cos_theta_reg, sin_theta_reg;
    logic signed [31:0] eye_z_reg, view_z_reg;
    logic [11:0]        half_w_reg, half_h_reg;
    logic [2:0]         cfg_idx;

    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_phi_reg   <= 16'sd16384;
            sin_phi_reg   <= '0;
            cos_theta_reg <= 16'sd16384;
            sin_theta_reg <= '0;
            eye_z_reg     <= 32'sd65536000;
            view_z_reg    <= '0;
            half_w_reg    <= 12'd320;
            half_h_reg    <= 12'd240;
        end
        else if (psel && penable && pwrite)
        begin
            case (cfg_idx)
                REG_COS_PHI:   cos_phi_reg   <= pwdata[15:0];
                REG_SIN_PHI:   sin_phi_reg   <= pwdata[15:0];
                REG_COS_THETA: cos_theta_reg <= pwdata[15:0];
                REG_SIN_THETA: sin_theta_reg <= pwdata[15:0];
                REG_EYE_Z:     eye_z_reg     <= pwdata;
                REG_VIEW_Z:    view_z_reg    <= pwdata;
                REG_HALF_W:    half_w_reg    <= pwdata[11:0];
                REG_HALF_H:    half_h_reg    <= pwdata[11:0];
                default:       ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_idx)
            REG_COS_PHI:   prdata = 32'(cos_phi_reg);
            REG_SIN_PHI:   prdata = 32'(sin_phi_reg);
            REG_COS_THETA: prdata = 32'(cos_theta_reg);
            REG_SIN_THETA: prdata = 32'(sin_theta_reg);
            REG_EYE_Z:     prdata = eye_z_reg;
            REG_VIEW_Z:    prdata = view_z_reg;
            REG_HALF_W:    prdata = {20'd0, half_w_reg};
            REG_HALF_H:    prdata = {20'd0, half_h_reg};
            default:       prdata = '0;
        endcase
    end

    // Valid bits of the front end.
    logic [FRONT_LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], start};
        end
    end

    // Stage 1: yaw products.
    logic signed [47:0] s1_cx_reg, s1_sz_reg, s1_sx_reg, s1_cz_reg;
    logic signed [31:0] s1_y_reg;
    logic [31:0]        s1_tint_reg;
    always_ff @(posedge clk)
    begin
        s1_cx_reg   <= cos_phi_reg * $signed(pos_x);
        s1_sz_reg   <= sin_phi_reg * $signed(pos_z);
        s1_sx_reg   <= sin_phi_reg * $signed(pos_x);
        s1_cz_reg   <= cos_phi_reg * $signed(pos_z);
        s1_y_reg    <= pos_y;
        s1_tint_reg <= tint;
    end

    // Round to nearest (ties up), drop the trig fraction, saturate to 32 bits.
    function automatic logic [32:0] trig_round(input logic signed [48:0] s);
        logic signed [49:0] t;
        logic signed [35:0] r;
        logic               hi;
        logic               lo;
        t  = 50'(s) + 50'sd8192;
        r  = 36'(t >>> TRIG_FRAC);
        hi = (r > 36'sd2147483647);
        lo = (r < -36'sd2147483648);
        if (hi)
        begin
            trig_round = {1'b1, 32'h7fff_ffff};
        end
        else if (lo)
        begin
            trig_round = {1'b1, 32'h8000_0000};
        end
        else
        begin
            trig_round = {1'b0, r[31:0]};
        end
    endfunction

    // Stage 2: rotated x and intermediate z.
    logic [32:0]        xr_w, zt_w;
    logic signed [31:0] s2_xr_reg, s2_zt_reg, s2_y_reg;
    logic               s2_flt_reg;
    logic [31:0]        s2_tint_reg;
    assign xr_w = trig_round(49'(s1_cx_reg) - 49'(s1_sz_reg));
    assign zt_w = trig_round(49'(s1_sx_reg) + 49'(s1_cz_reg));
    always_ff @(posedge clk)
    begin
        s2_xr_reg   <= xr_w[31:0];
        s2_zt_reg   <= zt_w[31:0];
        s2_flt_reg  <= xr_w[32] | zt_w[32];
        s2_y_reg    <= s1_y_reg;
        s2_tint_reg <= s1_tint_reg;
    end

    // Stage 3: pitch products.
    logic signed [47:0] s3_cy_reg, s3_sz_reg, s3_cz_reg, s3_sy_reg;
    logic signed [31:0] s3_xr_reg;
    logic               s3_flt_reg;
    logic [31:0]        s3_tint_reg;
    always_ff @(posedge clk)
    begin
        s3_cy_reg   <= cos_theta_reg * s2_y_reg;
        s3_sz_reg   <= sin_theta_reg * s2_zt_reg;
        s3_cz_reg   <= cos_theta_reg * s2_zt_reg;
        s3_sy_reg   <= sin_theta_reg * s2_y_reg;
        s3_xr_reg   <= s2_xr_reg;
        s3_flt_reg  <= s2_flt_reg;
        s3_tint_reg <= s2_tint_reg;
    end

    // Stage 4: rotated y and z.
    logic [32:0]        yr_w, zr_w;
    logic signed [31:0] s4_xr_reg, s4_yr_reg, s4_zr_reg;
    logic               s4_flt_reg;
    logic [31:0]        s4_tint_reg;
    assign yr_w = trig_round(49'(s3_cy_reg) + 49'(s3_sz_reg));
    assign zr_w = trig_round(49'(s3_cz_reg) - 49'(s3_sy_reg));
    always_ff @(posedge clk)
    begin
        s4_xr_reg   <= s3_xr_reg;
        s4_yr_reg   <= yr_w[31:0];
        s4_zr_reg   <= zr_w[31:0];
        s4_flt_reg  <= s3_flt_reg | yr_w[32] | zr_w[32];
        s4_tint_reg <= s3_tint_reg;
    end

    // Stage 5: numerator, denominator, magnitudes and signs.
    logic signed [32:0] num_w, den_w;
    logic [32:0]        num_mag_w, den_mag_w;
    logic [31:0]        s5_ax_reg, s5_ay_reg;
    logic [32:0]        s5_num_reg, s5_d_reg;
    side_t              s5_side_reg;
    assign num_w     = 33'(eye_z_reg) - 33'(view_z_reg);
    assign den_w     = 33'(eye_z_reg) - 33'(s4_zr_reg);
    assign num_mag_w = num_w[32] ? 33'(-num_w) : num_w;
    assign den_mag_w = den_w[32] ? 33'(-den_w) : den_w;
    always_ff @(posedge clk)
    begin
        s5_ax_reg <= s4_xr_reg[31] ? 32'(-s4_xr_reg) : s4_xr_reg;
        s5_ay_reg <= s4_yr_reg[31] ? 32'(-s4_yr_reg) : s4_yr_reg;
        s5_num_reg <= num_mag_w;
        s5_d_reg   <= (den_w == '0) ? 33'd1 : den_mag_w;
        s5_side_reg.neg_x <= s4_xr_reg[31] ^ num_w[32] ^ den_w[32];
        s5_side_reg.neg_y <= s4_yr_reg[31] ^ num_w[32] ^ den_w[32];
        s5_side_reg.dz    <= (den_w == '0);
        s5_side_reg.flt   <= s4_flt_reg;
        s5_side_reg.tint  <= s4_tint_reg;
    end

    // Stage 6: exact numerator products.
    logic [64:0] px_w, py_w;
    logic [63:0] s6_px_reg, s6_py_reg;
    logic [32:0] s6_d_reg;
    side_t       s6_side_reg;
    assign px_w = s5_ax_reg * s5_num_reg;
    assign py_w = s5_ay_reg * s5_num_reg;
    always_ff @(posedge clk)
    begin
        s6_px_reg   <= px_w[63:0];
        s6_py_reg   <= py_w[63:0];
        s6_d_reg    <= s5_d_reg;
        s6_side_reg <= s5_side_reg;
    end

    // Divider and the side line that keeps pace with it.
    logic            div_vld;
    logic [DIV_QW:0] qx, qy;
    logic            ovx, ovy;

    pvp_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (vld_reg[FRONT_LAT-1]),
        .p_x     (s6_px_reg),
        .p_y     (s6_py_reg),
        .d       (s6_d_reg),
        .vld_out (div_vld),
        .q_x     (qx),
        .q_y     (qy),
        .ovf_x   (ovx),
        .ovf_y   (ovy)
    );

    side_t side_reg [0:DIV_LAT-1];
    always_ff @(posedge clk)
    begin
        side_reg[0] <= s6_side_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // Output stage: sign, screen offset and saturation.
    localparam int SW = 48;
    side_t                sd;
    logic signed [SW-1:0] vx, vy, sx, sy;
    logic [DIV_QW:0]      mx, my;
    logic                 satx_hi, satx_lo, saty_hi, saty_lo;
    logic [31:0]          sx_next, sy_next;
    logic                 fault_next;

    always_comb
    begin
        sd = side_reg[DIV_LAT-1];
        mx = ovx ? (DIV_QW+1)'(1) << DIV_QW : qx;
        my = ovy ? (DIV_QW+1)'(1) << DIV_QW : qy;
        vx = sd.neg_x ? -SW'(mx) : SW'(mx);
        vy = sd.neg_y ? -SW'(my) : SW'(my);
        if (sd.dz)
        begin
            vx = '0;
            vy = '0;
        end
        sx = vx + (SW'(half_w_reg) << FRAC_BITS);
        sy = vy + (SW'(half_h_reg) << FRAC_BITS);
        satx_hi = (sx > SW'(32'sh7fff_ffff));
        satx_lo = (sx < -(SW'(1) << 31));
        saty_hi = (sy > SW'(32'sh7fff_ffff));
        saty_lo = (sy < -(SW'(1) << 31));
        sx_next = satx_hi ? 32'h7fff_ffff : (satx_lo ? 32'h8000_0000 : sx[31:0]);
        sy_next = saty_hi ? 32'h7fff_ffff : (saty_lo ? 32'h8000_0000 : sy[31:0]);
        fault_next = sd.flt | sd.dz | satx_hi | satx_lo | saty_hi | saty_lo;
    end

    always_ff @(posedge clk)
    begin
        screen_x <= sx_next;
        screen_y <= sy_next;
        plane_z  <= view_z_reg;
        tint_out <= sd.tint;
        fault    <= fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= div_vld;
        end
    end

endmodule

// File: rtl/pvp_div.sv
// Pipelined two-lane unsigned divider with round-to-nearest and overflow flag.
// Depends on pvp_pkg; one quotient bit is resolved per restoring stage.
module pvp_div
    import pvp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vld_in,
    input  logic [63:0]       p_x,
    input  logic [63:0]       p_y,
    input  logic [32:0]       d,
    output logic              vld_out,
    output logic [DIV_QW:0]   q_x,
    output logic [DIV_QW:0]   q_y,
    output logic              ovf_x,
    output logic              ovf_y
);

    localparam int CW = 68;

    logic [63:0]       rx_reg [0:DIV_QW];
    logic [63:0]       ry_reg [0:DIV_QW];
    logic [DIV_QW-1:0] qx_reg [0:DIV_QW];
    logic [DIV_QW-1:0] qy_reg [0:DIV_QW];
    logic [32:0]       d_reg  [0:DIV_QW];
    logic              ox_reg [0:DIV_QW];
    logic              oy_reg [0:DIV_QW];
    logic              vld_reg [0:DIV_QW+1];

    logic [CW-1:0] d_top;
    assign d_top = {{(CW-33){1'b0}}, d} << DIV_QW;

    // Entry stage: detect quotients that do not fit in DIV_QW bits.
    always_ff @(posedge clk)
    begin
        rx_reg[0] <= p_x;
        ry_reg[0] <= p_y;
        qx_reg[0] <= '0;
        qy_reg[0] <= '0;
        d_reg[0]  <= d;
        ox_reg[0] <= ({{(CW-64){1'b0}}, p_x} >= d_top);
        oy_reg[0] <= ({{(CW-64){1'b0}}, p_y} >= d_top);
    end

    // Restoring steps, most significant quotient bit first.
    for (genvar k = 0; k < DIV_QW; k++)
    begin : g_step
        localparam int SH = DIV_QW - 1 - k;
        logic [CW-1:0] dsh;
        logic [CW-1:0] rx_w;
        logic [CW-1:0] ry_w;
        logic          bx;
        logic          by;
        assign dsh  = {{(CW-33){1'b0}}, d_reg[k]} << SH;
        assign rx_w = {{(CW-64){1'b0}}, rx_reg[k]};
        assign ry_w = {{(CW-64){1'b0}}, ry_reg[k]};
        assign bx   = (rx_w >= dsh);
        assign by   = (ry_w >= dsh);
        always_ff @(posedge clk)
        begin
            rx_reg[k+1] <= bx ? 64'(rx_w - dsh) : rx_reg[k];
            ry_reg[k+1] <= by ? 64'(ry_w - dsh) : ry_reg[k];
            qx_reg[k+1] <= {qx_reg[k][DIV_QW-2:0], bx};
            qy_reg[k+1] <= {qy_reg[k][DIV_QW-2:0], by};
            d_reg[k+1]  <= d_reg[k];
            ox_reg[k+1] <= ox_reg[k];
            oy_reg[k+1] <= oy_reg[k];
        end
    end

    // Rounding stage: bump the quotient when twice the remainder reaches the divisor.
    logic [DIV_QW:0] qx_next;
    logic [DIV_QW:0] qy_next;
    always_comb
    begin
        qx_next = {1'b0, qx_reg[DIV_QW]} +
                  (DIV_QW+1)'({rx_reg[DIV_QW][32:0], 1'b0} >= {1'b0, d_reg[DIV_QW]});
        qy_next = {1'b0, qy_reg[DIV_QW]} +
                  (DIV_QW+1)'({ry_reg[DIV_QW][32:0], 1'b0} >= {1'b0, d_reg[DIV_QW]});
    end

    always_ff @(posedge clk)
    begin
        q_x   <= qx_next;
        q_y   <= qy_next;
        ovf_x <= ox_reg[DIV_QW];
        ovf_y <= oy_reg[DIV_QW];
    end

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_QW + 1; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= vld_in;
            for (int i = 1; i <= DIV_QW + 1; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign vld_out = vld_reg[DIV_QW+1];

endmodule

// File: rtl/pvp_checker.sv
// Port-level checker for the point view projection block, with its bind.
// Depends on pvp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pvp_checker
    import pvp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    // The block never refuses a request and never stalls the configuration port.
    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
    `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready)

    // Every result on done belongs to a request taken earlier on start.
    `ASSERT_IMPLY(a_done_has_request, clk, rst_n, done, $past(start, PIPE_LAT))

endmodule

bind point_view_projection_top pvp_checker u_pvp_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
